### hdl/slt_pkg.sv
// Shared types, field widths and operation codes for the sorted list table.
package slt_pkg;

  localparam int CMD_W       = 2;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 7;
  localparam int CNT_W       = 7;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_e_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MISSING = 2'd2
  } stat_e_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the input word and the per-cell compares
    logic update;   // apply the operation and load the result register
  } slt_ctl_t;

endpackage

### hdl/slt_ctrl.sv
// Controller state machine for the sorted list table.
module slt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output slt_pkg::slt_ctl_t ctl
);
  import slt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_UPD  = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid, out_valid_next;
  logic   out_free;

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;

  always_comb begin
    ctl.capture    = 1'b0;
    ctl.update     = 1'b0;
    state_next     = state;
    out_valid_next = out_valid && !m_axis_tready;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          ctl.capture = 1'b1;
          state_next  = S_UPD;
        end
      end
      S_UPD: begin
        // The result waits here until the output register can take it.
        if (out_free) begin
          ctl.update     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### hdl/slt_datapath.sv
// Datapath of the sorted list table: the row of entry cells, compares and result register.
module slt_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  slt_pkg::slt_ctl_t              ctl,
  input  logic [slt_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  output logic [slt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import slt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [VALUE_W-1:0] entries   [CAPACITY];
  logic signed [VALUE_W-1:0] cell_prev [CAPACITY];
  logic signed [VALUE_W-1:0] cell_next [CAPACITY];
  logic [CW-1:0]             fill, fill_next;

  logic [CMD_W-1:0]          op_cmd;
  logic signed [VALUE_W-1:0] op_value;
  logic [CAPACITY-1:0]       lt_vec, le_vec;

  logic [CMD_W-1:0]          in_cmd;
  logic signed [VALUE_W-1:0] in_value;

  logic [CAPACITY-1:0]       lt_edge, le_edge;
  logic [CW-1:0]             lt_cnt, le_cnt;
  logic                      full, found;
  logic                      do_ins, do_del;
  logic [CW-1:0]             res_pos;
  stat_e_t                   res_stat;
  logic [CW+POS_W-1:0]       pos_wide;
  logic [CW+CNT_W-1:0]       cnt_wide;

  logic [POS_W-1:0]          out_pos;
  logic [CNT_W-1:0]          out_cnt;
  logic [STAT_W-1:0]         out_stat;

  assign in_cmd   = s_axis_tdata[CMD_W-1:0];
  assign in_value = s_axis_tdata[CMD_W+VALUE_W-1:CMD_W];

  // Neighbor sources for the insert and delete shifts of each cell.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign cell_prev[k] = op_value;
    end else begin : g_rest
      assign cell_prev[k] = le_vec[k-1] ? op_value : entries[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign cell_next[k] = entries[k];
    end else begin : g_inner
      assign cell_next[k] = entries[k+1];
    end
  end

  // Both compare vectors are prefixes of ones since the table is sorted,
  // so the last set bit gives the count.
  assign lt_edge = lt_vec & ~(lt_vec >> 1);
  assign le_edge = le_vec & ~(le_vec >> 1);

  always_comb begin
    lt_cnt = '0;
    le_cnt = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      lt_cnt = lt_cnt | (lt_edge[k] ? CW'(k + 1) : '0);
      le_cnt = le_cnt | (le_edge[k] ? CW'(k + 1) : '0);
    end
  end

  assign full  = (fill == CW'(CAPACITY));
  assign found = |(le_vec & ~lt_vec);

  always_comb begin
    do_ins    = 1'b0;
    do_del    = 1'b0;
    fill_next = fill;
    res_pos   = '0;
    res_stat  = STAT_OK;
    case (op_cmd)
      CMD_INSERT: begin
        if (full) begin
          res_stat = STAT_FULL;
        end else begin
          do_ins    = 1'b1;
          fill_next = fill + CW'(1);
          res_pos   = le_cnt + CW'(1);
        end
      end
      CMD_DELETE: begin
        if (found) begin
          do_del    = 1'b1;
          fill_next = fill - CW'(1);
          res_pos   = lt_cnt + CW'(1);
        end else begin
          res_stat = STAT_MISSING;
        end
      end
      CMD_FIND: begin
        if (found) begin
          res_pos = lt_cnt + CW'(1);
        end else begin
          res_stat = STAT_MISSING;
        end
      end
      default: begin
        res_stat = STAT_OK;
      end
    endcase
  end

  assign pos_wide = {{POS_W{1'b0}}, res_pos};
  assign cnt_wide = {{CNT_W{1'b0}}, fill_next};

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op_cmd   <= in_cmd;
      op_value <= in_value;
      for (int k = 0; k < CAPACITY; k++) begin
        lt_vec[k] <= (CW'(k) < fill) && (entries[k] <  in_value);
        le_vec[k] <= (CW'(k) < fill) && (entries[k] <= in_value);
      end
    end
    if (ctl.update) begin
      for (int k = 0; k < CAPACITY; k++) begin
        if (do_ins && !le_vec[k]) begin
          entries[k] <= cell_prev[k];
        end else if (do_del && !lt_vec[k]) begin
          entries[k] <= cell_next[k];
        end
      end
      out_pos  <= pos_wide[POS_W-1:0];
      out_cnt  <= cnt_wide[CNT_W-1:0];
      out_stat <= res_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctl.update) begin
      fill <= fill_next;
    end
  end

  assign m_axis_tdata = {out_stat, out_cnt, out_pos};

endmodule

### hdl/sorted_list_table.sv
// A word is taken only in the idle state, where its compares are latched; the update state then
// shifts the cell row and loads its result into the output register, so words do not overlap.
// A new word is accepted while an earlier result still waits to be taken downstream.
// Reset (rst, synchronous, active high) empties the table and the output register.
// Entry contents are not cleared; the fill count alone marks which cells hold data.
module sorted_list_table #(
  parameter int CAPACITY = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  // s_axis_tdata, low bit up: cmd[1:0], value[33:2], zero pad[39:34]
  input  logic [slt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // m_axis_tdata, low bit up: position[6:0], entry_count[13:7], status[15:14]
  output logic [slt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready
);
  import slt_pkg::*;

  slt_ctl_t ctl;

  // The controller sequences each word through a compare cycle, where every
  // cell compares its entry with the incoming value, and an update cycle,
  // where the cells shift in place and the result register is loaded. The
  // update waits while the result register still holds an untaken word.
  slt_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .ctl           (ctl)
  );

  // The datapath holds the row of sorted cells and the fill count. Because
  // the table stays sorted, the compare vectors are runs of ones and their
  // lengths give the insert slot and the first matching position directly.
  slt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

### hdl/slt_checker.sv
// Port-level checker for the sorted list table and its bind.
module slt_checker #(
  parameter int CAPACITY = 64
) (
  input logic                            clk,
  input logic                            rst,
  input logic [slt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [slt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready
);
  import slt_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [POS_W-1:0]  pos;
  logic [CNT_W-1:0]  cnt;
  logic [STAT_W-1:0] stat;

  assign pos  = m_axis_tdata[POS_W-1:0];
  assign cnt  = m_axis_tdata[POS_W+CNT_W-1:POS_W];
  assign stat = m_axis_tdata[OUT_TDATA_W-1:POS_W+CNT_W];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word accepted during an operation");

  a_full_refusal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (stat == STAT_FULL) |-> (pos == '0) && (cnt == CAP_CNT))
    else $error("full status without a full table");

  a_missing_pos: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (stat == STAT_MISSING) |-> (pos == '0))
    else $error("not-found status with a position");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (CAPACITY > 126) || ((cnt <= CAP_CNT) && (pos <= cnt + 7'd1)))
    else $error("entry count or position out of range");

endmodule

bind sorted_list_table slt_checker #(.CAPACITY(CAPACITY)) u_slt_checker (.*);

### sim/sorted_list_table_tb.sv
// Self-checking testbench for the sorted list table: directed words, then random fill and drain.
`timescale 1ns / 1ps

module sorted_list_table_tb;

  import slt_pkg::*;

  localparam int          CAPACITY       = 64;
  localparam int          DIRECTED_WORDS = 22;
  localparam int          RANDOM_WORDS   = 450;
  localparam int          STALL_LIMIT    = 4000;
  localparam int          DRAIN_CYCLES   = 8;
  // The command field is two bits wide; the one code the block does not use.
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam logic [31:0] VAL_MIN        = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX        = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_NEG_ONE    = 32'hFFFF_FFFF;

  typedef enum int { PH_MIXED, PH_FILL, PH_DRAIN } phase_kind_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [CNT_W-1:0]  entry_count;
    logic [STAT_W-1:0] status;
  } table_result_t;

  // One directed step; when typed is set the result below is the one to compare.
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic               typed;
    logic [POS_W-1:0]   position;
    logic [CNT_W-1:0]   entry_count;
    logic [STAT_W-1:0]  status;
  } step_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;

  // Shadow copy of the table contents, kept in ascending order.
  logic signed [VALUE_W-1:0] held_values[$];
  table_result_t             pending_results[$];
  step_row_t                 directed_steps[DIRECTED_WORDS];

  int  mismatches   = 0;
  int  results_seen = 0;
  int  stall_cycles = 0;
  bit  no_idle      = 1'b0;

  sorted_list_table #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  always #10 clk = ~clk;

  // Applies one operation to the shadow table and returns the result the block must give.
  function automatic table_result_t apply_table_op(input logic [CMD_W-1:0] cmd,
                                                   input logic signed [VALUE_W-1:0] v);
    table_result_t r;
    int            slot;
    int            hit;
    r.position = '0;
    r.status   = STAT_OK;
    hit = -1;
    for (int k = 0; k < held_values.size(); k++) begin
      if (hit < 0 && held_values[k] == v) begin
        hit = k;
      end
    end
    case (cmd)
      CMD_INSERT: begin
        if (held_values.size() >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          // The new value goes in front of the first strictly greater entry.
          slot = held_values.size();
          for (int k = held_values.size() - 1; k >= 0; k--) begin
            if (v < held_values[k]) begin
              slot = k;
            end
          end
          held_values.insert(slot, v);
          r.position = POS_W'(slot + 1);
        end
      end
      CMD_DELETE: begin
        if (hit < 0) begin
          r.status = STAT_MISSING;
        end else begin
          held_values.delete(hit);
          r.position = POS_W'(hit + 1);
        end
      end
      CMD_FIND: begin
        if (hit < 0) begin
          r.status = STAT_MISSING;
        end else begin
          r.position = POS_W'(hit + 1);
        end
      end
      default: begin
        // The unused code changes nothing and reports success.
      end
    endcase
    r.entry_count = CNT_W'(held_values.size());
    return r;
  endfunction

  // Values are mostly ones already held or close to each other, so that hits and
  // duplicates are common; the rest are extremes and full-range noise.
  function automatic logic [VALUE_W-1:0] pick_value(input int held_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < held_pct && held_values.size() != 0) begin
      return held_values[$urandom_range(held_values.size() - 1)];
    end
    roll = $urandom_range(99);
    if (roll < 50) begin
      return VALUE_W'(int'($urandom_range(16)) - 8);
    end else if (roll < 75) begin
      case ($urandom_range(3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return VAL_NEG_ONE;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input phase_kind_t phase);
    int roll;
    roll = $urandom_range(99);
    case (phase)
      PH_FILL: begin
        if (roll < 85) return CMD_INSERT;
        if (roll < 95) return CMD_FIND;
        return CMD_DELETE;
      end
      PH_DRAIN: begin
        if (roll < 75) return CMD_DELETE;
        if (roll < 90) return CMD_FIND;
        if (roll < 96) return CMD_INSERT;
        return CMD_UNUSED;
      end
      default: begin
        if (roll < 40) return CMD_INSERT;
        if (roll < 70) return CMD_DELETE;
        if (roll < 95) return CMD_FIND;
        return CMD_UNUSED;
      end
    endcase
  endfunction

  // Offers one word, waits for the handshake and returns the predicted result.
  // The caller has just passed a rising edge, so every drive here lands on an edge.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                           output table_result_t predicted);
    while (!no_idle && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - VALUE_W - CMD_W){1'b0}}, value, cmd};
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    predicted = apply_table_op(cmd, value);
  endtask

  task automatic note_mismatch(input string field, input int got, input int want);
    $display("mismatch in %s of result %0d: got %0d, expected %0d at %0t",
             field, results_seen, got, want, $realtime);
    mismatches++;
  endtask

  // Stimulus: directed steps first, then phases that mix operations, fill the table,
  // work on it while full, and drain it again.
  initial begin
    table_result_t predicted;
    table_result_t typed_result;
    phase_kind_t   phase;
    int            phase_idx;
    int            phase_words;
    int            tail_words;
    int            sent_random;
    logic [CMD_W-1:0] cmd;

    directed_steps = '{
      // Empty table: find and delete miss, the unused code is a no-op.
      '{CMD_FIND,    32'h0,         1'b1, 7'd0, 7'd0, STAT_MISSING},
      '{CMD_DELETE,  32'h0,         1'b1, 7'd0, 7'd0, STAT_MISSING},
      '{CMD_UNUSED,  VAL_NEG_ONE,   1'b1, 7'd0, 7'd0, STAT_OK},
      // Extremes, then equal values that must land behind their twins.
      '{CMD_INSERT,  VAL_MIN,       1'b1, 7'd1, 7'd1, STAT_OK},
      '{CMD_INSERT,  VAL_MAX,       1'b1, 7'd2, 7'd2, STAT_OK},
      '{CMD_INSERT,  32'h0,         1'b1, 7'd2, 7'd3, STAT_OK},
      '{CMD_INSERT,  32'h0,         1'b1, 7'd3, 7'd4, STAT_OK},
      '{CMD_INSERT,  VAL_NEG_ONE,   1'b1, 7'd2, 7'd5, STAT_OK},
      '{CMD_INSERT,  VAL_MIN,       1'b1, 7'd2, 7'd6, STAT_OK},
      '{CMD_INSERT,  VAL_MAX,       1'b1, 7'd7, 7'd7, STAT_OK},
      // Finds report the first of several equal entries.
      '{CMD_FIND,    32'h0,         1'b1, 7'd4, 7'd7, STAT_OK},
      '{CMD_FIND,    VAL_MAX,       1'b1, 7'd6, 7'd7, STAT_OK},
      '{CMD_FIND,    VAL_MIN,       1'b1, 7'd1, 7'd7, STAT_OK},
      '{CMD_FIND,    32'h1,         1'b1, 7'd0, 7'd7, STAT_MISSING},
      '{CMD_DELETE,  32'h0,         1'b1, 7'd4, 7'd6, STAT_OK},
      '{CMD_DELETE,  VAL_MIN,       1'b1, 7'd1, 7'd5, STAT_OK},
      '{CMD_DELETE,  32'h5555_5555, 1'b1, 7'd0, 7'd5, STAT_MISSING},
      '{CMD_UNUSED,  32'hAAAA_AAAA, 1'b1, 7'd0, 7'd5, STAT_OK},
      '{CMD_DELETE,  VAL_MAX,       1'b0, 7'd0, 7'd0, STAT_OK},
      '{CMD_INSERT,  32'hAAAA_AAAA, 1'b0, 7'd0, 7'd0, STAT_OK},
      '{CMD_INSERT,  32'h5555_5555, 1'b0, 7'd0, 7'd0, STAT_OK},
      '{CMD_FIND,    32'h5555_5555, 1'b0, 7'd0, 7'd0, STAT_OK}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_WORDS; i++) begin
      send_word(directed_steps[i].cmd, directed_steps[i].value, predicted);
      if (directed_steps[i].typed) begin
        typed_result.position    = directed_steps[i].position;
        typed_result.entry_count = directed_steps[i].entry_count;
        typed_result.status      = directed_steps[i].status;
        pending_results.insert(pending_results.size(), typed_result);
      end else begin
        pending_results.insert(pending_results.size(), predicted);
      end
    end

    phase_idx   = 0;
    phase_words = 0;
    tail_words  = 0;
    sent_random = 0;
    while (sent_random < RANDOM_WORDS) begin
      // Phase order: mixed, fill to full, mixed while full, drain to empty.
      phase = (phase_idx == 1) ? PH_FILL : (phase_idx == 3) ? PH_DRAIN : PH_MIXED;
      cmd = pick_cmd(phase);
      send_word(cmd, pick_value(phase == PH_DRAIN ? 80 : 40), predicted);
      pending_results.insert(pending_results.size(), predicted);
      sent_random++;
      phase_words++;
      // A long stretch in the middle runs with neither side holding back.
      no_idle = (sent_random >= 150 && sent_random < 230);
      if (phase == PH_FILL && held_values.size() == CAPACITY) begin
        tail_words++;
      end else if (phase == PH_DRAIN && held_values.size() == 0) begin
        tail_words++;
      end
      if ((phase == PH_MIXED && phase_words >= 40) ||
          (phase == PH_FILL && tail_words >= 8) ||
          (phase == PH_DRAIN && tail_words >= 4) ||
          phase_words >= 150) begin
        phase_idx   = (phase_idx + 1) % 4;
        phase_words = 0;
        tail_words  = 0;
      end
    end

    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[sorted_list_table] OK");
    end else begin
      $display("[sorted_list_table] ERROR");
    end
    $finish;
  end

  // Result side: random back-pressure, and each accepted word is compared with
  // the oldest expectation field by field.
  always @(posedge clk) begin
    table_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected word", int'(m_axis_tdata), 0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[POS_W-1:0] !== want.position) begin
          note_mismatch("position", int'(m_axis_tdata[POS_W-1:0]), int'(want.position));
        end
        if (m_axis_tdata[POS_W+CNT_W-1:POS_W] !== want.entry_count) begin
          note_mismatch("entry_count", int'(m_axis_tdata[POS_W+CNT_W-1:POS_W]),
                        int'(want.entry_count));
        end
        if (m_axis_tdata[OUT_TDATA_W-1:POS_W+CNT_W] !== want.status) begin
          note_mismatch("status", int'(m_axis_tdata[OUT_TDATA_W-1:POS_W+CNT_W]),
                        int'(want.status));
        end
      end
      results_seen++;
    end
    m_axis_tready <= no_idle || ($urandom_range(99) >= 27);
  end

  // Ends the run when no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[sorted_list_table] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
